FILE: rtl/core/tccc_pkg.sv
// Shared types and character codes for the text console cursor control unit.
package tccc_pkg;

  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic              write_valid;
    logic [ROW_W-1:0]  write_row;
    logic [COL_W-1:0]  write_col;
    logic [CHAR_W-1:0] write_char;
    logic [ATTR_W-1:0] write_attr;
    logic              clear_screen;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } tccc_result_t;

endpackage

FILE: rtl/core/tccc_cursor.sv
// Next-cursor and cell-write logic for one character.
module tccc_cursor import tccc_pkg::*; #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 8,
  parameter int unsigned PH_W      = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1
) (
  input  logic [CHAR_W-1:0] char_i,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [PH_W-1:0]   phase_i,
  output tccc_result_t      result_o,
  output logic [ROW_W-1:0]  row_o,
  output logic [COL_W-1:0]  col_o,
  output logic [PH_W-1:0]   phase_o
);

  logic [ROW_W:0]  row_n;
  logic [COL_W:0]  col_n;
  logic [PH_W-1:0] ph_n;
  logic [PH_W:0]   ph_inc;
  logic [COL_W:0]  tab_adv;
  logic            clr;

  assign ph_inc  = {1'b0, phase_i} + 1'b1;
  assign tab_adv = (COL_W + 1)'(TAB_WIDTH) - {{(COL_W + 1 - PH_W){1'b0}}, phase_i};

  always_comb begin
    row_n    = {1'b0, row_i};
    col_n    = {1'b0, col_i};
    ph_n     = phase_i;
    clr      = 1'b0;
    result_o = '0;
    case (char_i)
      CH_NEWLINE: begin
        row_n = row_n + 1'b1;
        col_n = '0;
        ph_n  = '0;
      end
      CH_TAB: begin
        // phase tracks col mod TAB_WIDTH, so this lands on the next stop
        col_n = col_n + tab_adv;
        ph_n  = '0;
      end
      CH_BACKSPACE: begin
        if (col_i != '0) begin
          col_n = col_n - 1'b1;
          ph_n  = (phase_i == '0) ? PH_W'(TAB_WIDTH - 1) : phase_i - 1'b1;
        end
      end
      CH_FORMFEED: begin
        clr   = 1'b1;
        row_n = '0;
        col_n = '0;
        ph_n  = '0;
      end
      CH_RETURN: begin
        col_n = '0;
        ph_n  = '0;
      end
      default: begin
        result_o.write_valid = 1'b1;
        result_o.write_row   = row_i;
        result_o.write_col   = col_i;
        result_o.write_char  = char_i;
        result_o.write_attr  = attr_i;
        col_n = col_n + 1'b1;
        ph_n  = (ph_inc == (PH_W + 1)'(TAB_WIDTH)) ? '0 : ph_inc[PH_W-1:0];
      end
    endcase

    // wrap past the last column
    if (col_n >= (COL_W + 1)'(COLUMNS)) begin
      row_n = row_n + 1'b1;
      col_n = '0;
      ph_n  = '0;
    end
    // past the last row: clear and home, no scrolling
    if (row_n >= (ROW_W + 1)'(ROWS)) begin
      clr   = 1'b1;
      row_n = '0;
      col_n = '0;
      ph_n  = '0;
    end

    result_o.clear_screen = clr;
    result_o.cursor_row   = row_n[ROW_W-1:0];
    result_o.cursor_col   = col_n[COL_W-1:0];
  end

  assign row_o   = row_n[ROW_W-1:0];
  assign col_o   = col_n[COL_W-1:0];
  assign phase_o = ph_n;

endmodule

FILE: rtl/core/text_console_cursor_control_unit.sv
// Text console cursor control: top level with input, state and result registers.
//
// Usage:
//   Input channel: in_valid_i / in_ready_o carry one character byte
//   (char_in_i) per transaction. Output channel: out_valid_o / out_ready_i
//   carry one result per character: an optional cell write (row, column,
//   character, attribute), a clear-screen request and the new cursor.
//   An accepted character is held in the input register, and its result is
//   registered in the result register. Throughput is one character per cycle
//   while the receiver does not stall; the cursor update is a single pass of
//   logic between those registers, closed by the cursor registers per character.
//   A stalled receiver holds the result register; the input register takes
//   one more character, after which in_ready_o drops until the result moves.
//   Reset homes the cursor to row 0, column 0, empties both registers and
//   sets the attribute to 0x0F. cfg_we_i writes the attribute; write it only
//   while no character is in flight.
module text_console_cursor_control_unit import tccc_pkg::*; #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAR_W-1:0] char_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              write_valid_o,
  output logic [ROW_W-1:0]  write_row_o,
  output logic [COL_W-1:0]  write_col_o,
  output logic [CHAR_W-1:0] write_char_o,
  output logic [ATTR_W-1:0] write_attr_o,
  output logic              clear_screen_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [COL_W-1:0]  cursor_col_o
);

  localparam int unsigned PH_W = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  logic              in_valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              out_valid_q;
  tccc_result_t      result_q, result_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [ATTR_W-1:0] attr_q;
  logic              advance;

  // result register frees when empty or taken this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;

  tccc_cursor #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH),
    .PH_W     (PH_W)
  ) u_cursor (
    .char_i  (char_q),
    .attr_i  (attr_q),
    .row_i   (row_q),
    .col_i   (col_q),
    .phase_i (phase_q),
    .result_o(result_d),
    .row_o   (row_d),
    .col_o   (col_d),
    .phase_o (phase_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      phase_q     <= '0;
      attr_q      <= ATTR_RESET;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          row_q   <= row_d;
          col_q   <= col_d;
          phase_q <= phase_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
    end
    if (advance && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_valid_o  = result_q.write_valid;
  assign write_row_o    = result_q.write_row;
  assign write_col_o    = result_q.write_col;
  assign write_char_o   = result_q.write_char;
  assign write_attr_o   = result_q.write_attr;
  assign clear_screen_o = result_q.clear_screen;
  assign cursor_row_o   = result_q.cursor_row;
  assign cursor_col_o   = result_q.cursor_col;

endmodule

FILE: rtl/core/tccc_checker.sv
// Port-level checks for the text console cursor control unit, bound to the top level.
module tccc_checker import tccc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              write_valid_o,
  input logic [ROW_W-1:0]  write_row_o,
  input logic [COL_W-1:0]  write_col_o,
  input logic [CHAR_W-1:0] write_char_o,
  input logic [ATTR_W-1:0] write_attr_o,
  input logic              clear_screen_o,
  input logic [ROW_W-1:0]  cursor_row_o,
  input logic [COL_W-1:0]  cursor_col_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_row_o)
      && $stable(cursor_col_o) && $stable(clear_screen_o) && $stable(write_valid_o))
    else $error("stalled result changed");

  // control codes carry an all-zero cell write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_row_o == '0 && write_col_o == '0
      && write_char_o == '0 && write_attr_o == '0)
    else $error("cell fields not zero without a write");

  // a clear always homes the cursor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_screen_o |-> cursor_row_o == '0 && cursor_col_o == '0)
    else $error("clear without cursor home");

  // control codes never write a cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |-> write_char_o != CH_NEWLINE
      && write_char_o != CH_TAB && write_char_o != CH_BACKSPACE
      && write_char_o != CH_FORMFEED && write_char_o != CH_RETURN)
    else $error("control code written to a cell");

endmodule

bind text_console_cursor_control_unit tccc_checker u_tccc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .write_valid_o (write_valid_o),
  .write_row_o   (write_row_o),
  .write_col_o   (write_col_o),
  .write_char_o  (write_char_o),
  .write_attr_o  (write_attr_o),
  .clear_screen_o(clear_screen_o),
  .cursor_row_o  (cursor_row_o),
  .cursor_col_o  (cursor_col_o)
);

FILE: tb/sv/text_console_cursor_control_unit_tb.sv
// Testbench for the text console cursor control unit: directed, edge and random character streams.
module text_console_cursor_control_unit_tb;
  import tccc_pkg::*;

  localparam int unsigned COLUMNS        = 80;
  localparam int unsigned ROWS           = 25;
  localparam int unsigned TAB_WIDTH      = 8;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          PRINT_LIMIT    = 50;
  localparam int          PHASE_CHARS    = 500;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [ATTR_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [CHAR_W-1:0] char_in_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              write_valid_o;
  logic [ROW_W-1:0]  write_row_o;
  logic [COL_W-1:0]  write_col_o;
  logic [CHAR_W-1:0] write_char_o;
  logic [ATTR_W-1:0] write_attr_o;
  logic              clear_screen_o;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [COL_W-1:0]  cursor_col_o;

  // Predicted console state
  int unsigned       cur_row   = 0;
  int unsigned       cur_col   = 0;
  logic [ATTR_W-1:0] text_attr = ATTR_RESET;

  tccc_result_t pending_results[$];

  bit idle_on        = 1'b1;
  int chars_sent     = 0;
  int results_seen   = 0;
  int cells_written  = 0;
  int screen_clears  = 0;
  int attr_writes    = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  text_console_cursor_control_unit #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .write_valid_o (write_valid_o),
    .write_row_o   (write_row_o),
    .write_col_o   (write_col_o),
    .write_char_o  (write_char_o),
    .write_attr_o  (write_attr_o),
    .clear_screen_o(clear_screen_o),
    .cursor_row_o  (cursor_row_o),
    .cursor_col_o  (cursor_col_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Work out the result of one character and advance the cursor
  function automatic tccc_result_t predict_char(input logic [CHAR_W-1:0] ch);
    tccc_result_t res;
    int unsigned  row;
    int unsigned  col;
    res = '0;
    row = cur_row;
    col = cur_col;
    case (ch)
      CH_NEWLINE: begin
        row = row + 1;
        col = 0;
      end
      CH_TAB:       col = col + (TAB_WIDTH - (col % TAB_WIDTH));
      CH_BACKSPACE: if (col > 0) col = col - 1;
      CH_FORMFEED: begin
        res.clear_screen = 1'b1;
        row = 0;
        col = 0;
      end
      CH_RETURN:    col = 0;
      default: begin
        res.write_valid = 1'b1;
        res.write_row   = ROW_W'(cur_row);
        res.write_col   = COL_W'(cur_col);
        res.write_char  = ch;
        res.write_attr  = text_attr;
        col = col + 1;
      end
    endcase
    // wrap to the next row, then home on running off the bottom
    if (col >= COLUMNS) begin
      row = row + 1;
      col = 0;
    end
    if (row >= ROWS) begin
      res.clear_screen = 1'b1;
      row = 0;
      col = 0;
    end
    cur_row = row;
    cur_col = col;
    res.cursor_row = ROW_W'(row);
    res.cursor_col = COL_W'(col);
    return res;
  endfunction

  function automatic bit is_control(input logic [CHAR_W-1:0] ch);
    case (ch)
      CH_NEWLINE, CH_TAB, CH_BACKSPACE, CH_FORMFEED, CH_RETURN: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] random_glyph();
    logic [CHAR_W-1:0] ch;
    do ch = CHAR_W'($urandom_range(0, 255)); while (is_control(ch));
    return ch;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  // Check each result transaction, then record each accepted character
  always @(posedge clk_i) begin : result_monitor
    tccc_result_t want;
    tccc_result_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{write_valid_o, write_row_o, write_col_o, write_char_o, write_attr_o,
                clear_screen_o, cursor_row_o, cursor_col_o};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
        end else begin
          want = pending_results.pop_front();
          check_field("write_valid",  got.write_valid,  want.write_valid);
          check_field("write_row",    got.write_row,    want.write_row);
          check_field("write_col",    got.write_col,    want.write_col);
          check_field("write_char",   got.write_char,   want.write_char);
          check_field("write_attr",   got.write_attr,   want.write_attr);
          check_field("clear_screen", got.clear_screen, want.clear_screen);
          check_field("cursor_row",   got.cursor_row,   want.cursor_row);
          check_field("cursor_col",   got.cursor_col,   want.cursor_col);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_char(char_in_i);
        pending_results.push_back(want);
        if (want.write_valid) cells_written++;
        if (want.clear_screen) screen_clears++;
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL text_console_cursor_control_unit");
        $finish;
      end
    end
  end

  // Receiver: stall at random while idling is on
  always @(posedge clk_i) begin
    out_ready_i <= !(idle_on && ($urandom_range(0, 99) < 15));
  end

  // Present one character and hold it until accepted; valid stays high on return
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    if (idle_on && ($urandom_range(0, 99) < 6)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    chars_sent++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_seen < chars_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] attr);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= attr;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    text_attr  = attr;
    attr_writes++;
  endtask

  // Home the cursor, then walk to the given cell
  task automatic move_cursor(input int unsigned row, input int unsigned col);
    send_char(CH_FORMFEED);
    repeat (row) send_char(CH_NEWLINE);
    repeat (col / TAB_WIDTH) send_char(CH_TAB);
    repeat (col % TAB_WIDTH) send_char(random_glyph());
  endtask

  task automatic test_printing_extremes();
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_char(8'h7F);
    send_char(8'h41);
  endtask

  task automatic test_control_codes();
    send_char(CH_TAB);
    send_char(CH_BACKSPACE);
    send_char(CH_RETURN);
    send_char(CH_BACKSPACE);
    send_char(CH_NEWLINE);
    send_char(CH_TAB);
    send_char(CH_TAB);
    send_char(CH_FORMFEED);
    send_char(CH_BACKSPACE);
    send_char(CH_RETURN);
  endtask

  task automatic test_attribute_extremes();
    set_attribute(8'h00);
    send_char(8'h55);
    send_char(8'hAA);
    set_attribute(8'hFF);
    send_char(8'h2A);
    send_char(8'hD5);
  endtask

  task automatic test_screen_edges();
    idle_on = 1'b0;
    move_cursor(3, COLUMNS - 1);
    send_char(CH_TAB);
    move_cursor(10, COLUMNS - 3);
    send_char(CH_TAB);
    move_cursor(7, COLUMNS - 1);
    send_char(random_glyph());
    move_cursor(12, COLUMNS - 1);
    send_char(CH_BACKSPACE);
    send_char(CH_RETURN);
    move_cursor(ROWS - 1, COLUMNS - 1);
    send_char(random_glyph());
    move_cursor(ROWS - 1, COLUMNS - 6);
    send_char(CH_TAB);
    move_cursor(ROWS - 1, 10);
    send_char(CH_NEWLINE);
    move_cursor(ROWS - 1, COLUMNS - 2);
    send_char(random_glyph());
    send_char(random_glyph());
    idle_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_attribute(8'hFF);
        1:       set_attribute(8'h00);
        2:       set_attribute(ATTR_RESET);
        default: set_attribute(ATTR_W'($urandom_range(0, 255)));
      endcase
      for (int n = 0; n < PHASE_CHARS; n++) begin
        // hold off until the pipe is empty once mid-stream
        if (phase == 1 && n == PHASE_CHARS / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 8)       send_char(CH_NEWLINE);
        else if (pick < 14) send_char(CH_TAB);
        else if (pick < 19) send_char(CH_BACKSPACE);
        else if (pick < 23) send_char(CH_RETURN);
        else if (pick < 24) send_char(CH_FORMFEED);
        else                send_char(CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_printing_extremes();
    test_control_codes();
    test_attribute_extremes();
    test_screen_edges();
    test_random_stream();
    drain_results();

    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("covered %0d characters: %0d cell writes, %0d screen clears, %0d attribute writes",
             chars_sent, cells_written, screen_clears, attr_writes);
    $display("checked %0d results, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS text_console_cursor_control_unit");
    end else begin
      $display("FAIL text_console_cursor_control_unit");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tccc_pkg.sv
rtl/core/tccc_cursor.sv
rtl/core/text_console_cursor_control_unit.sv
rtl/core/tccc_checker.sv
tb/sv/text_console_cursor_control_unit_tb.sv
